// File: rtl/qcnf_pkg.sv
// shared types, constants and neighbor arithmetic for the quadtree neighbor finder
package qcnf_pkg;

    localparam int NUM_LEVELS  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_DIR     = 8;

    typedef logic [15:0]        coord_t;
    typedef logic [3:0]         level_t;
    typedef logic [2:0]         dir_t;
    typedef logic [31:0]        code_t;
    typedef logic [NUM_DIR-1:0] dir_mask_t;

    // step along one axis
    typedef enum logic [1:0] {
        OFS_NEG  = 2'b00,
        OFS_ZERO = 2'b01,
        OFS_POS  = 2'b10
    } ofs_t;

    typedef struct packed {
        coord_t    x;
        coord_t    y;
        level_t    level;
        dir_mask_t keep;
    } qcnf_entry_t;

    typedef struct packed {
        logic        valid;
        qcnf_entry_t entry;
    } qcnf_head_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   flip;
    } qcnf_nb_t;

    function automatic level_t clamp_level(level_t lvl);
        level_t r;
        r = lvl;
        if (int'(lvl) > NUM_LEVELS - 1)
            r = level_t'(NUM_LEVELS - 1);
        return r;
    endfunction

    // level+1 low bits set
    function automatic coord_t path_mask(level_t lvl);
        return coord_t'(16'hFFFF >> (4'd15 - lvl));
    endfunction

    function automatic code_t interleave(coord_t px, coord_t py);
        code_t c;
        c = '0;
        for (int i = 0; i < 16; i++)
        begin
            c[2*i]   = px[i];
            c[2*i+1] = py[i];
        end
        return c;
    endfunction

    // neighbor in scan position d, centre already masked and level clamped
    function automatic qcnf_nb_t nb_calc(coord_t cx, coord_t cy, level_t lvl, dir_t d);
        ofs_t     col;
        ofs_t     row;
        coord_t   m;
        qcnf_nb_t r;
        m = path_mask(lvl);
        unique case (d)
            3'd0: begin col = OFS_NEG;  row = OFS_NEG;  end
            3'd1: begin col = OFS_ZERO; row = OFS_NEG;  end
            3'd2: begin col = OFS_POS;  row = OFS_NEG;  end
            3'd3: begin col = OFS_NEG;  row = OFS_ZERO; end
            3'd4: begin col = OFS_POS;  row = OFS_ZERO; end
            3'd5: begin col = OFS_NEG;  row = OFS_POS;  end
            3'd6: begin col = OFS_ZERO; row = OFS_POS;  end
            default: begin col = OFS_POS; row = OFS_POS; end
        endcase
        case (col)
            OFS_NEG: r.x = (cx - 16'd1) & m;
            OFS_POS: r.x = (cx + 16'd1) & m;
            default: r.x = cx;
        endcase
        case (row)
            OFS_NEG: r.y = (cy - 16'd1) & m;
            OFS_POS: r.y = (cy + 16'd1) & m;
            default: r.y = cy;
        endcase
        r.flip = ((row == OFS_NEG) && (cy == 16'd0)) || ((row == OFS_POS) && (cy == m));
        // over the pole: same row, opposite meridian
        if (r.flip)
        begin
            r.y = cy;
            r.x = (r.x ^ (16'd1 << lvl)) & m;
        end
        return r;
    endfunction

endpackage

// File: rtl/qcnf_front.sv
// front end: masks the centre cell and marks which neighbors survive duplicate removal
module qcnf_front
    import qcnf_pkg::*;
(
    input  coord_t      cell_x,
    input  coord_t      cell_y,
    input  level_t      cell_level,
    output qcnf_entry_t entry
);

    level_t   lvl;
    coord_t   m;
    coord_t   cx;
    coord_t   cy;
    qcnf_nb_t cand [NUM_DIR];
    logic     dup  [NUM_DIR];

    always_comb
    begin
        lvl = clamp_level(cell_level);
        m   = path_mask(lvl);
        cx  = cell_x & m;
        cy  = cell_y & m;
        for (int j = 0; j < NUM_DIR; j++)
            cand[j] = nb_calc(cx, cy, lvl, dir_t'(j));
        // a candidate is dropped if it is the centre or matches an earlier one
        for (int j = 0; j < NUM_DIR; j++)
        begin
            dup[j] = (cand[j].x == cx) && (cand[j].y == cy);
            for (int k = 0; k < j; k++)
                if ((cand[k].x == cand[j].x) && (cand[k].y == cand[j].y))
                    dup[j] = 1'b1;
        end
        entry.x     = cx;
        entry.y     = cy;
        entry.level = lvl;
        for (int j = 0; j < NUM_DIR; j++)
            entry.keep[j] = !dup[j];
    end

endmodule

// File: rtl/qcnf_queue.sv
// short queue of classified cells between front and back
module qcnf_queue
    import qcnf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  qcnf_entry_t wr_entry,
    output logic        full,
    input  logic        head_pop,
    output qcnf_head_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qcnf_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wr_en;
    logic             rd_en;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = head_pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// File: rtl/qcnf_back.sv
// back end: walks the surviving directions of the head cell, one word per cycle while pop keeps up
module qcnf_back
    import qcnf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qcnf_head_t head,
    output logic       head_pop,
    output logic       empty,
    input  logic       pop,
    output coord_t     nb_x,
    output coord_t     nb_y,
    output level_t     nb_level,
    output code_t      nb_code,
    output dir_t       direction,
    output logic       pole_flip,
    output logic       last
);

    logic      active_reg, active_next;
    dir_mask_t work_reg, work_next;
    logic      out_valid_reg, out_valid_next;
    coord_t    nb_x_reg;
    coord_t    nb_y_reg;
    level_t    nb_level_reg;
    code_t     nb_code_reg;
    dir_t      dir_reg;
    logic      flip_reg;
    logic      last_reg;

    dir_mask_t eff;
    dir_mask_t rest;
    dir_t      sel;
    logic      advance;
    logic      emit;
    logic      drop;
    qcnf_nb_t  nb;

    always_comb
    begin
        // remaining directions: the fresh mask until the first word leaves
        eff = active_reg ? work_reg : head.entry.keep;
        sel = '0;
        for (int i = NUM_DIR - 1; i >= 0; i--)
            if (eff[i])
                sel = dir_t'(i);
        rest     = eff & ~(dir_mask_t'(1) << sel);
        advance  = !out_valid_reg || pop;
        emit     = head.valid && (eff != '0) && advance;
        drop     = head.valid && (eff == '0);
        head_pop = (emit && (rest == '0)) || drop;
        nb       = nb_calc(head.entry.x, head.entry.y, head.entry.level, sel);

        active_next = active_reg;
        work_next   = work_reg;
        if (emit)
        begin
            active_next = (rest != '0);
            work_next   = rest;
        end
        else if (drop)
            active_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (emit)
        begin
            nb_x_reg     <= nb.x;
            nb_y_reg     <= nb.y;
            nb_level_reg <= head.entry.level;
            nb_code_reg  <= interleave(nb.x, nb.y);
            dir_reg      <= sel;
            flip_reg     <= nb.flip;
            last_reg     <= (rest == '0);
        end
    end

    assign empty     = !out_valid_reg;
    assign nb_x      = nb_x_reg;
    assign nb_y      = nb_y_reg;
    assign nb_level  = nb_level_reg;
    assign nb_code   = nb_code_reg;
    assign direction = dir_reg;
    assign pole_flip = flip_reg;
    assign last      = last_reg;

endmodule

// File: rtl/quadtree_cell_neighbor_finder.sv
// top level of the quadtree cell neighbor finder
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------
//  cell in  | push / full      | cell_x, cell_y, cell_level
//  result   | empty / pop      | nb_x, nb_y, nb_level, nb_code, direction,
//           |                  | pole_flip, last
//
// a cell gives three to eight result words, one per cycle while the result side pops,
// one for each surviving neighbor (eight above level 1, fewer only at level 0
// and on the pole rows of level 1); the back end walks the direction mask to emit them.
// a cell is classified in the cycle it is pushed and held in a queue slot; its first word
// is registered at the output. reset empties the queue and the output; no clearing pass.
// full rises whenever the queue holds QUEUE_DEPTH_P cells, which back-to-back cells reach.
module quadtree_cell_neighbor_finder
    import qcnf_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  coord_t cell_x,
    input  coord_t cell_y,
    input  level_t cell_level,
    output logic   empty,
    input  logic   pop,
    output coord_t nb_x,
    output coord_t nb_y,
    output level_t nb_level,
    output code_t  nb_code,
    output dir_t   direction,
    output logic   pole_flip,
    output logic   last
);

    qcnf_entry_t entry;
    qcnf_head_t  head;
    logic        head_pop;

    qcnf_front u_front (
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_level (cell_level),
        .entry      (entry)
    );

    qcnf_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (entry),
        .full     (full),
        .head_pop (head_pop),
        .head     (head)
    );

    qcnf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_pop  (head_pop),
        .empty     (empty),
        .pop       (pop),
        .nb_x      (nb_x),
        .nb_y      (nb_y),
        .nb_level  (nb_level),
        .nb_code   (nb_code),
        .direction (direction),
        .pole_flip (pole_flip),
        .last      (last)
    );

endmodule

// File: rtl/qcnf_checker.sv
// port-level checks for the neighbor finder, bound to the top level
module qcnf_checker
    import qcnf_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   empty,
    input logic   pop,
    input coord_t nb_x,
    input coord_t nb_y,
    input level_t nb_level,
    input code_t  nb_code,
    input dir_t   direction,
    input logic   pole_flip,
    input logic   last
);

    coord_t code_x;
    coord_t code_y;
    coord_t m;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            code_x[i] = nb_code[2*i];
            code_y[i] = nb_code[2*i+1];
        end
        m = path_mask(nb_level);
    end

    // a waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(nb_code) && $stable(direction)
            && $stable(last) && $stable(pole_flip))
        else $error("result word changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (code_x == nb_x) && (code_y == nb_y))
        else $error("path code does not match coordinates");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (int'(nb_level) <= NUM_LEVELS - 1) && ((nb_x & ~m) == '0)
            && ((nb_y & ~m) == '0))
        else $error("neighbor outside its level");

    a_pole: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pole_flip |-> (direction != 3'd3) && (direction != 3'd4))
        else $error("pole crossing on a same-row step");

    // directions rise within a run
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last ##1 !empty |-> direction > $past(direction))
        else $error("directions out of scan order");

endmodule

bind quadtree_cell_neighbor_finder qcnf_checker u_qcnf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .nb_x      (nb_x),
    .nb_y      (nb_y),
    .nb_level  (nb_level),
    .nb_code   (nb_code),
    .direction (direction),
    .pole_flip (pole_flip),
    .last      (last)
);

// File: bench/quadtree_cell_neighbor_finder_tb.sv
// self-checking bench for the quadtree cell neighbor finder, directed table then random cells
module testbench;
    import qcnf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 64;
    localparam int N_ROWS      = 20;
    localparam int N_TYPED     = 6;

    typedef struct packed {
        coord_t x;
        coord_t y;
        level_t level;
        code_t  code;
        dir_t   dir;
        logic   flip;
        logic   last;
    } nb_word_t;

    typedef struct {
        coord_t x;
        coord_t y;
        level_t level;
        int     n_typed;
    } cell_row_t;

    logic   clk;
    logic   rst_n;
    logic   push;
    logic   full;
    coord_t cell_x;
    coord_t cell_y;
    level_t cell_level;
    logic   empty;
    logic   pop;
    coord_t nb_x;
    coord_t nb_y;
    level_t nb_level;
    code_t  nb_code;
    dir_t   direction;
    logic   pole_flip;
    logic   last;

    nb_word_t pending_neighbors[$];
    int       errors        = 0;
    int       send_idle_pct = 0;
    int       pop_stall_pct = 0;
    bit       hold_start    = 1'b0;

    // level 0 grid is 2x2, so most neighbors collapse onto the centre or repeat
    nb_word_t level0_words[N_TYPED] = '{
        '{16'h0001, 16'h0000, 4'd0, 32'h1, 3'd1, 1'b1, 1'b0},
        '{16'h0001, 16'h0001, 4'd0, 32'h3, 3'd5, 1'b0, 1'b0},
        '{16'h0000, 16'h0001, 4'd0, 32'h2, 3'd6, 1'b0, 1'b1},
        '{16'h0000, 16'h0000, 4'd0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{16'h0001, 16'h0000, 4'd0, 32'h1, 3'd1, 1'b0, 1'b0},
        '{16'h0000, 16'h0001, 4'd0, 32'h2, 3'd3, 1'b0, 1'b1}
    };

    cell_row_t cell_table[N_ROWS] = '{
        '{16'h0000, 16'h0000, 4'd0,  3},
        '{16'hFFFF, 16'hFFFF, 4'd0,  3},
        '{16'h0001, 16'h0000, 4'd0,  0},
        '{16'h0000, 16'h0001, 4'd0,  0},
        '{16'h0000, 16'h0000, 4'd15, 0},
        '{16'hFFFF, 16'hFFFF, 4'd15, 0},
        '{16'h8000, 16'h0000, 4'd15, 0},
        '{16'h7FFF, 16'hFFFF, 4'd15, 0},
        '{16'h1234, 16'h5678, 4'd15, 0},
        '{16'h0000, 16'h0001, 4'd1,  0},
        '{16'h0003, 16'h0002, 4'd1,  0},
        '{16'hFFFF, 16'h0000, 4'd1,  0},
        '{16'h0005, 16'h0009, 4'd3,  0},
        '{16'hA5A5, 16'h5A5A, 4'd7,  0},
        '{16'h0000, 16'h007F, 4'd6,  0},
        '{16'h00FF, 16'h0000, 4'd7,  0},
        '{16'hAAAA, 16'h5555, 4'd14, 0},
        '{16'h5555, 16'hAAAA, 4'd15, 0},
        '{16'h0001, 16'hFFFE, 4'd15, 0},
        '{16'hFFFE, 16'h0001, 4'd15, 0}
    };

    quadtree_cell_neighbor_finder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_level (cell_level),
        .empty      (empty),
        .pop        (pop),
        .nb_x       (nb_x),
        .nb_y       (nb_y),
        .nb_level   (nb_level),
        .nb_code    (nb_code),
        .direction  (direction),
        .pole_flip  (pole_flip),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("quadtree_cell_neighbor_finder regression: fail");
        $finish;
    end

    function automatic string fmt_word(nb_word_t w);
        return $sformatf("x=%h y=%h lvl=%0d code=%h dir=%0d flip=%b last=%b",
                         w.x, w.y, w.level, w.code, w.dir, w.flip, w.last);
    endfunction

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // neighbor words of one cell in scan order, repeats and the centre dropped
    task automatic find_neighbors(coord_t raw_x, coord_t raw_y, level_t raw_level);
        level_t   lvl;
        coord_t   msk;
        coord_t   cx;
        coord_t   cy;
        coord_t   nx;
        coord_t   ny;
        code_t    code;
        logic     flip;
        int       dx;
        int       dy;
        int       n;
        bit       dup;
        nb_word_t run[8];
        lvl = raw_level;
        if (int'(raw_level) > NUM_LEVELS - 1)
            lvl = level_t'(NUM_LEVELS - 1);
        msk = coord_t'((1 << (int'(lvl) + 1)) - 1);
        cx = raw_x & msk;
        cy = raw_y & msk;
        n = 0;
        for (int pos = 0; pos < 9; pos++)
        begin
            if (pos == 4)
                continue;
            dx = pos % 3 - 1;
            dy = pos / 3 - 1;
            nx = coord_t'((int'(cx) + dx) & int'(msk));
            ny = coord_t'((int'(cy) + dy) & int'(msk));
            flip = 1'b0;
            // stepping over a pole lands on the opposite meridian, same row
            if ((dy < 0 && cy == '0) || (dy > 0 && cy == msk))
            begin
                ny = cy;
                nx = (nx ^ (coord_t'(1) << lvl)) & msk;
                flip = 1'b1;
            end
            dup = (nx == cx && ny == cy);
            for (int k = 0; k < n; k++)
                if (run[k].x == nx && run[k].y == ny)
                    dup = 1'b1;
            if (dup)
                continue;
            code = '0;
            for (int i = 0; i < 16; i++)
            begin
                code[2*i]   = nx[i];
                code[2*i+1] = ny[i];
            end
            run[n].x     = nx;
            run[n].y     = ny;
            run[n].level = lvl;
            run[n].code  = code;
            run[n].dir   = dir_t'((pos < 4) ? pos : pos - 1);
            run[n].flip  = flip;
            run[n].last  = 1'b0;
            n++;
        end
        if (n > 0)
            run[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_neighbors.push_back(run[k]);
    endtask

    task automatic check_word();
        nb_word_t want;
        nb_word_t got;
        got = '{nb_x, nb_y, nb_level, nb_code, direction, pole_flip, last};
        if (pending_neighbors.size() == 0)
        begin
            note_error({"unexpected word: ", fmt_word(got)});
            return;
        end
        want = pending_neighbors.pop_front();
        if (got.x != want.x || got.y != want.y || got.level != want.level
            || got.code != want.code || got.dir != want.dir
            || got.flip != want.flip || got.last != want.last)
            note_error({"mismatch: expected ", fmt_word(want), " got ", fmt_word(got)});
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_word();
    end

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_start)
            begin
                hold_left = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0)
            begin
                pop = 1'b0;
                hold_left--;
            end
            else
                pop = ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // returns at the edge where the cell is taken
    task automatic offer_cell(coord_t x, coord_t y, level_t l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push = 1'b0;
            cell_x = coord_t'($urandom);
            cell_y = coord_t'($urandom);
            cell_level = level_t'($urandom);
            @(posedge clk);
        end
        @(negedge clk);
        push = 1'b1;
        cell_x = x;
        cell_y = y;
        cell_level = l;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic run_random(int n_cells, int send_pct, int stall_pct, bit with_hold);
        coord_t x;
        coord_t y;
        coord_t m;
        level_t l;
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
        for (int i = 0; i < n_cells; i++)
        begin
            l = level_t'($urandom_range(15));
            // low levels are where the wrap and pole cases fold together
            if ($urandom_range(3) == 0)
                l = level_t'($urandom_range(2));
            m = coord_t'((1 << (int'(l) + 1)) - 1);
            x = coord_t'($urandom);
            y = coord_t'($urandom);
            case ($urandom_range(5))
                0: y = y & ~m;
                1: y = y | m;
                2: x = x & ~m;
                3: x = x | m;
                default: ;
            endcase
            offer_cell(x, y, l);
            find_neighbors(x, y, l);
            if (with_hold && i == 3)
                hold_start = 1'b1;
        end
    endtask

    initial
    begin
        int typed_idx;
        typed_idx = 0;
        rst_n = 1'b0;
        push = 1'b0;
        cell_x = '0;
        cell_y = '0;
        cell_level = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            offer_cell(cell_table[r].x, cell_table[r].y, cell_table[r].level);
            if (cell_table[r].n_typed > 0)
            begin
                for (int k = 0; k < cell_table[r].n_typed; k++)
                    pending_neighbors.push_back(level0_words[typed_idx + k]);
                typed_idx += cell_table[r].n_typed;
            end
            else
                find_neighbors(cell_table[r].x, cell_table[r].y, cell_table[r].level);
        end

        run_random(25, 0, 0, 1'b1);
        run_random(25, 81, 0, 1'b0);
        run_random(25, 0, 81, 1'b0);
        run_random(25, 11, 11, 1'b1);

        @(negedge clk);
        push = 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (errors == 0)
            $display("quadtree_cell_neighbor_finder regression: pass");
        else
            $display("quadtree_cell_neighbor_finder regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/qcnf_pkg.sv
rtl/qcnf_front.sv
rtl/qcnf_queue.sv
rtl/qcnf_back.sv
rtl/quadtree_cell_neighbor_finder.sv
rtl/qcnf_checker.sv
bench/quadtree_cell_neighbor_finder_tb.sv
